// File: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// Calendar clock package
// Shared types, event codes, reset values and segment tables for the
// calendar clock with seven-segment view.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Depth of the queue between the front and the back part.
    localparam int CCS_QUEUE_DEPTH = 2;

    // Event codes carried in the func field.
    localparam logic [2:0] FUNC_TICK       = 3'd0;
    localparam logic [2:0] FUNC_CLR_SEC    = 3'd1;
    localparam logic [2:0] FUNC_STEP_MIN   = 3'd2;
    localparam logic [2:0] FUNC_STEP_HOUR  = 3'd3;
    localparam logic [2:0] FUNC_STEP_DAY   = 3'd4;
    localparam logic [2:0] FUNC_STEP_MONTH = 3'd5;
    localparam logic [2:0] FUNC_STEP_YEAR  = 3'd6;
    localparam logic [2:0] FUNC_NONE       = 3'd7;

    // View codes.
    localparam logic [1:0] VIEW_TIME   = 2'd0;
    localparam logic [1:0] VIEW_DATE   = 2'd1;
    localparam logic [1:0] VIEW_NAME   = 2'd2;
    localparam logic [1:0] VIEW_UNUSED = 2'd3;

    // Separator codes between digit pairs.
    localparam logic [7:0] SEP_TIME = 8'h7F;
    localparam logic [7:0] SEP_DATE = 8'hBF;

    // Reset values of the clock.
    localparam logic [5:0] RST_SECOND = 6'd0;
    localparam logic [5:0] RST_MINUTE = 6'd0;
    localparam logic [4:0] RST_HOUR   = 5'd12;
    localparam logic [4:0] RST_DAY    = 5'd28;
    localparam logic [3:0] RST_MONTH  = 4'd5;
    localparam logic [6:0] RST_YEAR   = 7'd21;

    // Input beat.
    typedef struct packed {
        logic [2:0] func;
        logic [1:0] view;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic [7:0] seg_digit0;
        logic [7:0] seg_digit1;
        logic [7:0] seg_digit2;
        logic [7:0] seg_digit3;
        logic [7:0] seg_digit4;
        logic [7:0] seg_digit5;
        logic [7:0] seg_digit6;
        logic [7:0] seg_digit7;
        logic [2:0] weekday;
    } result_t;

    // Classified event, as held in the queue.
    typedef struct packed {
        logic       tick;
        logic       clr_sec;
        logic       step_min;
        logic       step_hour;
        logic       step_day;
        logic       step_month;
        logic       step_year;
        logic [1:0] view;
    } op_t;

    // Clock and calendar counters.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } clk_state_t;

    // What the display decoder needs for one result.
    typedef struct packed {
        clk_state_t st;
        logic [1:0] view;
    } snap_t;

    // Segment code of a decimal digit; values of ten and above wrap.
    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [3:0] v;
        v = (d >= 4'd10) ? d - 4'd10 : d;
        case (v)
            4'd0:    digit_seg = 8'hC0;
            4'd1:    digit_seg = 8'hF9;
            4'd2:    digit_seg = 8'hA4;
            4'd3:    digit_seg = 8'hB0;
            4'd4:    digit_seg = 8'h99;
            4'd5:    digit_seg = 8'h92;
            4'd6:    digit_seg = 8'h82;
            4'd7:    digit_seg = 8'hF8;
            4'd8:    digit_seg = 8'h80;
            4'd9:    digit_seg = 8'h90;
            default: digit_seg = 8'hC0;
        endcase
    endfunction

    // Weekday offset of a month; months outside the year use January's.
    function automatic logic [2:0] month_key(input logic [3:0] m);
        case (m)
            4'd2:    month_key = 3'd3;
            4'd3:    month_key = 3'd3;
            4'd4:    month_key = 3'd6;
            4'd5:    month_key = 3'd1;
            4'd6:    month_key = 3'd4;
            4'd7:    month_key = 3'd6;
            4'd8:    month_key = 3'd2;
            4'd9:    month_key = 3'd5;
            4'd10:   month_key = 3'd0;
            4'd11:   month_key = 3'd3;
            4'd12:   month_key = 3'd5;
            default: month_key = 3'd0;
        endcase
    endfunction

    // Segment code of one position of a weekday name, position 0 rightmost.
    function automatic logic [7:0] name_seg(input logic [2:0] wd, input logic [2:0] pos);
        logic [63:0] row;
        case (wd)
            3'd0:    row = 64'hFF_A1_A3_C8_CF_AB_C2_A3;
            3'd1:    row = 64'hFF_92_86_C2_C1_AB_A1_88;
            3'd2:    row = 64'hFF_FF_FF_87_86_AF_C6_88;
            3'd3:    row = 64'hFF_FF_98_C1_88_AF_87_88;
            3'd4:    row = 64'hFF_FF_98_C1_CF_AB_87_88;
            3'd5:    row = 64'hFF_FF_FF_92_86_89_87_88;
            3'd6:    row = 64'hFF_FF_92_88_83_88_A1_A3;
            default: row = 64'hFF_FF_FF_FF_FF_FF_FF_FF;
        endcase
        name_seg = row[{pos, 3'b000} +: 8];
    endfunction

endpackage

// File: rtl/ccs_front.sv
// ----------------------------------------------------------------------------
// Calendar clock front part
// Accepts event beats, classifies each into a set of update flags and a
// normalised view, and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module ccs_front #(
    parameter int DEPTH = ccs_pkg::CCS_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  ccs_pkg::item_t  item,
    output logic            op_valid,
    input  logic            op_ready,
    output ccs_pkg::op_t    op
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t              queue_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    op_t              op_in;
    logic             push, pop;

    // Classify the incoming event.
    always_comb
    begin
        op_in = '0;
        case (item.func)
            FUNC_TICK:       op_in.tick       = 1'b1;
            FUNC_CLR_SEC:    op_in.clr_sec    = 1'b1;
            FUNC_STEP_MIN:   op_in.step_min   = 1'b1;
            FUNC_STEP_HOUR:  op_in.step_hour  = 1'b1;
            FUNC_STEP_DAY:   op_in.step_day   = 1'b1;
            FUNC_STEP_MONTH: op_in.step_month = 1'b1;
            FUNC_STEP_YEAR:  op_in.step_year  = 1'b1;
            FUNC_NONE:       op_in.tick       = 1'b0;
            default:         op_in.tick       = 1'b0;
        endcase
        // The unused view code shows the time.
        op_in.view = (item.view == VIEW_UNUSED) ? VIEW_TIME : item.view;
    end

    assign item_ready = (count_reg != FULL_CNT);
    assign op_valid   = (count_reg != '0);
    assign op         = queue_mem[rd_ptr_reg];
    assign push       = item_valid && item_ready;
    assign pop        = op_valid && op_ready;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// File: rtl/ccs_back.sv
// ----------------------------------------------------------------------------
// Calendar clock back part
// Applies one classified event to the clock and calendar counters and
// holds the updated counters with the view until the result beat is taken.
// ----------------------------------------------------------------------------
module ccs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          op_valid,
    output logic          op_ready,
    input  ccs_pkg::op_t  op,
    output logic          result_valid,
    input  logic          result_ready,
    output ccs_pkg::snap_t snap
);
    import ccs_pkg::*;

    clk_state_t state_reg, state_next;
    logic [1:0] view_reg;
    logic       valid_reg, valid_next;
    logic       pop;

    // Length of the current month, with February in leap years.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd2:    month_len = leap ? 5'd29 : 5'd28;
            4'd4:    month_len = 5'd30;
            4'd6:    month_len = 5'd30;
            4'd9:    month_len = 5'd30;
            4'd11:   month_len = 5'd30;
            default: month_len = 5'd31;
        endcase
    endfunction

    assign op_ready     = !valid_reg || result_ready;
    assign pop          = op_valid && op_ready;
    assign result_valid = valid_reg;
    assign snap         = '{st: state_reg, view: view_reg};

    // Counter update for one event.
    always_comb
    begin
        logic [6:0] sec_inc;
        logic [6:0] min_inc;
        logic [5:0] hour_inc;
        logic [4:0] day_inc;
        logic [4:0] mon_inc;
        logic [7:0] year_inc;
        logic       day_carry;
        logic [6:0] year_stepped;

        state_next = state_reg;
        sec_inc    = {1'b0, state_reg.second} + 7'd1;
        min_inc    = {1'b0, state_reg.minute} + 7'd1;
        hour_inc   = {1'b0, state_reg.hour} + 6'd1;
        day_inc    = state_reg.day + 5'd1;
        mon_inc    = {1'b0, state_reg.month} + 5'd1;
        year_inc   = {1'b0, state_reg.year} + 8'd1;
        year_stepped = (year_inc > 8'd99) ? 7'd0 : year_inc[6:0];
        day_carry  = 1'b0;

        // Seconds tick with carry through minute and hour into the day.
        if (op.tick)
        begin
            if (sec_inc >= 7'd60)
            begin
                state_next.second = '0;
                if (min_inc >= 7'd60)
                begin
                    state_next.minute = '0;
                    if (hour_inc >= 6'd24)
                    begin
                        state_next.hour = '0;
                        day_carry       = 1'b1;
                    end
                    else
                    begin
                        state_next.hour = hour_inc[4:0];
                    end
                end
                else
                begin
                    state_next.minute = min_inc[5:0];
                end
            end
            else
            begin
                state_next.second = sec_inc[5:0];
            end
        end
        if (op.clr_sec)
        begin
            state_next.second = '0;
        end
        if (op.step_min)
        begin
            state_next.minute = (min_inc >= 7'd60) ? 6'd0 : min_inc[5:0];
        end
        if (op.step_hour)
        begin
            state_next.hour = (hour_inc >= 6'd24) ? 5'd0 : hour_inc[4:0];
        end

        // Day step, with month and year carry past the month's last day.
        if (op.step_day || day_carry)
        begin
            if ((day_inc > month_len(state_reg.month, state_reg.year[1:0] == 2'd0))
                || (day_inc == 5'd0))
            begin
                state_next.day = 5'd1;
                if (state_reg.month >= 4'd12)
                begin
                    state_next.month = 4'd1;
                    state_next.year  = year_stepped;
                end
                else
                begin
                    state_next.month = mon_inc[3:0];
                end
            end
            else
            begin
                state_next.day = day_inc;
            end
        end
        if (op.step_month)
        begin
            state_next.month = (mon_inc > 5'd12) ? 4'd1 : mon_inc[3:0];
        end
        if (op.step_year)
        begin
            state_next.year = year_stepped;
        end
    end

    // Result holding register: full until the downstream side takes it.
    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{second: RST_SECOND, minute: RST_MINUTE, hour: RST_HOUR,
                           day: RST_DAY, month: RST_MONTH, year: RST_YEAR};
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            view_reg <= op.view;
        end
    end

endmodule

// File: rtl/ccs_render.sv
// ----------------------------------------------------------------------------
// Calendar clock display decoder
// Works out the weekday from the held date and turns the held counters
// into eight active-low segment codes for the selected view.
// ----------------------------------------------------------------------------
module ccs_render (
    input  ccs_pkg::snap_t   snap,
    output ccs_pkg::result_t result
);
    import ccs_pkg::*;

    // Tens and units of a value below 128, by multiplying with 205/2048.
    function automatic logic [7:0] split10(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod    = 15'(v) * 15'd205;
        q       = prod[14:11];
        r       = v - 7'(q) * 7'd10;
        split10 = {q, r[3:0]};
    endfunction

    // Remainder by seven of an 8-bit value, folding on eight being one mod seven.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1   = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[7:6]);
        s2   = 4'(s1[2:0]) + 4'(s1[4:3]);
        mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    logic [7:0] sec_bcd, min_bcd, hour_bcd, day_bcd, mon_bcd, year_bcd;
    logic [7:0] wd_sum;
    logic       jan_feb_leap;
    logic [2:0] wd;

    // Weekday from the date; January and February of a leap year lose one.
    always_comb
    begin
        jan_feb_leap = (snap.st.year[1:0] == 2'd0) &&
                       !(snap.st.month inside {[4'd3:4'd12]});
        wd_sum = 8'(month_key(snap.st.month)) + 8'(snap.st.day)
               + 8'(snap.st.year) + 8'(snap.st.year[6:2]) + 8'd6
               + (jan_feb_leap ? 8'd6 : 8'd0);
        wd = mod7(wd_sum);
    end

    assign sec_bcd  = split10({1'b0, snap.st.second});
    assign min_bcd  = split10({1'b0, snap.st.minute});
    assign hour_bcd = split10({2'b0, snap.st.hour});
    assign day_bcd  = split10({2'b0, snap.st.day});
    assign mon_bcd  = split10({3'b0, snap.st.month});
    assign year_bcd = split10(snap.st.year);

    // Segment codes for the selected view.
    always_comb
    begin
        result.weekday = wd;
        case (snap.view)
            VIEW_DATE:
            begin
                result.seg_digit0 = digit_seg(year_bcd[3:0]);
                result.seg_digit1 = digit_seg(year_bcd[7:4]);
                result.seg_digit2 = SEP_DATE;
                result.seg_digit3 = digit_seg(mon_bcd[3:0]);
                result.seg_digit4 = digit_seg(mon_bcd[7:4]);
                result.seg_digit5 = SEP_DATE;
                result.seg_digit6 = digit_seg(day_bcd[3:0]);
                result.seg_digit7 = digit_seg(day_bcd[7:4]);
            end
            VIEW_NAME:
            begin
                result.seg_digit0 = name_seg(wd, 3'd0);
                result.seg_digit1 = name_seg(wd, 3'd1);
                result.seg_digit2 = name_seg(wd, 3'd2);
                result.seg_digit3 = name_seg(wd, 3'd3);
                result.seg_digit4 = name_seg(wd, 3'd4);
                result.seg_digit5 = name_seg(wd, 3'd5);
                result.seg_digit6 = name_seg(wd, 3'd6);
                result.seg_digit7 = name_seg(wd, 3'd7);
            end
            default:
            begin
                result.seg_digit0 = digit_seg(sec_bcd[3:0]);
                result.seg_digit1 = digit_seg(sec_bcd[7:4]);
                result.seg_digit2 = SEP_TIME;
                result.seg_digit3 = digit_seg(min_bcd[3:0]);
                result.seg_digit4 = digit_seg(min_bcd[7:4]);
                result.seg_digit5 = SEP_TIME;
                result.seg_digit6 = digit_seg(hour_bcd[3:0]);
                result.seg_digit7 = digit_seg(hour_bcd[7:4]);
            end
        endcase
    end

endmodule

// File: rtl/calendar_clock_seven_segment_top.sv
// ----------------------------------------------------------------------------
// Calendar clock with seven-segment view
// Top level: front queue, counter update and display decoding.
// ----------------------------------------------------------------------------
// Each item beat is one clock event (seconds tick, clear seconds, or a step
// of minute, hour, day, month or year) together with a view choice; each
// produces exactly one result beat of eight active-low segment codes and the
// weekday, showing the clock after that event. The block takes one item beat
// per clock cycle while the front queue has room. A result beat is offered
// once its item has passed the front queue (QUEUE_DEPTH entries) and the
// counter update has loaded the register that holds the result until it is
// taken. While a result is held, the queue keeps taking beats until it is
// full. The date runs over 2000 to 2099 with every fourth year a leap year.
module calendar_clock_seven_segment_top #(
    parameter int QUEUE_DEPTH = ccs_pkg::CCS_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ccs_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ccs_pkg::result_t result
);
    import ccs_pkg::*;

    op_t   op;
    logic  op_valid;
    logic  op_ready;
    snap_t snap;

    // Front part: classification and queue.
    ccs_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op)
    );

    // Back part: counters and held result.
    ccs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .snap         (snap)
    );

    // Display codes from the held counters.
    ccs_render u_render (
        .snap   (snap),
        .result (result)
    );

endmodule

// File: rtl/ccs_checker.sv
// ----------------------------------------------------------------------------
// Calendar clock port checker
// Watches the top level's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input ccs_pkg::result_t result
);
    import ccs_pkg::*;

    // No result beat is offered while in reset.
    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // A held result beat stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("held result beat changed");

    // An item accepted with nothing offered is followed by an offered result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |-> ##2 result_valid)
        else $error("result missing after accepted item");

    // The weekday is always a real day.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.weekday != 3'd7)
        else $error("weekday out of range");

    // Both separators of a time or date view agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.seg_digit2 == SEP_TIME || result.seg_digit2 == SEP_DATE)
        |-> result.seg_digit5 == result.seg_digit2)
        else $error("separators disagree");

endmodule

bind calendar_clock_seven_segment_top ccs_checker u_ccs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
